### rtl/button_gesture_detector_defines.svh
// Assertion macros for the button gesture detector RTL.
`ifndef BUTTON_GESTURE_DETECTOR_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_DEFINES_SVH

// Clocked assertion, masked while reset is low.
`define BGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define BGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bgd_pkg.sv
// Shared types, register indexes and event codes for the gesture detector.
package bgd_pkg;

  localparam int STAMP_W          = 32;
  localparam int LEVEL_BITS       = 6;
  localparam int INDEX_W          = 3;
  localparam int TALLY_W          = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;
  localparam int BUTTON_COUNT_DEF = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 3'd4;

  // Reset values
  localparam logic [LEVEL_BITS-1:0] ENABLE_RST       = 6'd63;
  localparam logic [7:0]            DEBOUNCE_RST     = 8'd20;
  localparam logic [15:0]           LONG_PRESS_RST   = 16'd500;
  localparam logic [15:0]           DOUBLE_CLICK_RST = 16'd300;
  localparam logic [15:0]           REPEAT_RST       = 16'd100;

  // Request kinds
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_RELEASED = 3'd2,
    EV_CLICK    = 3'd3,
    EV_DOUBLE   = 3'd4,
    EV_LONG     = 3'd5,
    EV_REPEAT   = 3'd6
  } event_t;

  typedef struct packed {
    logic [7:0]  debounce;
    logic [15:0] long_press;
    logic [15:0] double_click;
    logic [15:0] repeat_ms;
  } timing_t;

  // One button's record as held in the state memory
  typedef struct packed {
    logic               pressed_now;
    logic               pressed_before;
    logic [STAMP_W-1:0] press_stamp;
    logic [STAMP_W-1:0] release_stamp;
    logic [STAMP_W-1:0] change_stamp;
    logic [STAMP_W-1:0] repeat_stamp;
    logic [TALLY_W-1:0] click_tally;
    logic               long_flag;
    logic               long_reported;
    logic               repeat_flag;
  } entry_t;

endpackage

### rtl/button_gesture_detector.sv
// Button gesture detector top level: sequencer, config registers, output register.
//
// Use: a tick request (action 0) carries the raw contact levels and advances the
// millisecond clock by one; a poll request (action 1) names a button and returns
// its highest-priority pending event, clearing it. Every request gives one result
// carrying the event code (always none for a tick) and the debounced pressed mask.
// Input and result channels use valid/stall; the config channel uses valid/ready
// and is always ready. The user must write config only while the block is idle;
// the block itself does not enforce it. A tick sweeps the per-button records
// through the state memory, one read per cycle, write-back in the cycle after it;
// then come the drain and done states. The result is registered once the output
// register is free. A poll works only its own record; an absent button skips to done.
// The next request can be taken in the cycle after the result is registered.
// One request is in flight at a time; in_stall stays high until its result is registered.
// Reset (synchronous, rst_n low) clears the clock, the config to its defaults
// and the valid bits of the state memory, so all button records read as zero.
// If the receiver stalls, the result holds in the output register; the next
// request is still taken and runs, waiting only to hand over its own result.
module button_gesture_detector #(
  parameter int BUTTON_COUNT = bgd_pkg::BUTTON_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [bgd_pkg::LEVEL_BITS-1:0]    in_raw_levels,
  input  logic [bgd_pkg::INDEX_W-1:0]       in_button_index,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_event_code,
  output logic [bgd_pkg::LEVEL_BITS-1:0]    out_pressed_mask,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  `include "button_gesture_detector_defines.svh"

  localparam int AW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  // only the first six buttons have a level and an enable bit
  localparam int NT = (BUTTON_COUNT < bgd_pkg::LEVEL_BITS) ? BUTTON_COUNT
                                                           : bgd_pkg::LEVEL_BITS;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

  state_t                            state_r;
  logic                              act_r;
  logic [bgd_pkg::LEVEL_BITS-1:0]    levels_r;
  logic [AW-1:0]                     cnt_r;
  logic                              wb_vld_r;
  logic [AW-1:0]                     wb_addr_r;
  logic [bgd_pkg::STAMP_W-1:0]       time_r;
  logic [bgd_pkg::LEVEL_BITS-1:0]    mask_r;
  bgd_pkg::event_t                   ev_r;
  logic                              out_valid_r;
  bgd_pkg::event_t                   out_ev_r;
  logic [bgd_pkg::LEVEL_BITS-1:0]    out_mask_r;

  logic [bgd_pkg::LEVEL_BITS-1:0]    enable_r;
  bgd_pkg::timing_t                  tcfg_r;

  logic                              in_acc;
  logic                              idx_ok;
  logic [AW+bgd_pkg::INDEX_W-1:0]    idx_ext;
  logic [AW-1:0]                     poll_addr;
  logic                              rd_en;
  logic                              mem_we;
  logic                              wb_en;
  logic                              wb_lvl;
  logic                              out_load;
  bgd_pkg::entry_t                   rd_entry;
  bgd_pkg::entry_t                   upd_entry;
  bgd_pkg::event_t                   upd_ev;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign idx_ok    = (32'(in_button_index) < BUTTON_COUNT);
  assign idx_ext   = {{AW{1'b0}}, in_button_index};
  assign poll_addr = idx_ext[AW-1:0];

  assign rd_en    = (state_r == S_RUN);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // level and enable of the button being written back
  always_comb begin
    wb_en  = 1'b0;
    wb_lvl = 1'b0;
    for (int j = 0; j < NT; j++) begin
      if (32'(wb_addr_r) == j) begin
        wb_en  = enable_r[j];
        wb_lvl = levels_r[j];
      end
    end
  end

  // a poll only reaches the write-back stage for a button that exists
  assign mem_we = wb_vld_r && ((act_r == bgd_pkg::ACT_POLL) || wb_en);

  bgd_mem #(
    .DEPTH (BUTTON_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (wb_addr_r),
    .wdata (upd_entry),
    .re    (rd_en),
    .raddr (cnt_r),
    .rdata (rd_entry)
  );

  bgd_upd u_upd (
    .is_poll (act_r == bgd_pkg::ACT_POLL),
    .level   (wb_lvl),
    .now     (time_r),
    .tcfg    (tcfg_r),
    .cur     (rd_entry),
    .nxt     (upd_entry),
    .ev      (upd_ev)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r            <= bgd_pkg::ENABLE_RST;
      tcfg_r.debounce     <= bgd_pkg::DEBOUNCE_RST;
      tcfg_r.long_press   <= bgd_pkg::LONG_PRESS_RST;
      tcfg_r.double_click <= bgd_pkg::DOUBLE_CLICK_RST;
      tcfg_r.repeat_ms    <= bgd_pkg::REPEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bgd_pkg::REG_ENABLE:       enable_r            <= cfg_data[bgd_pkg::LEVEL_BITS-1:0];
        bgd_pkg::REG_DEBOUNCE:     tcfg_r.debounce     <= cfg_data[7:0];
        bgd_pkg::REG_LONG_PRESS:   tcfg_r.long_press   <= cfg_data;
        bgd_pkg::REG_DOUBLE_CLICK: tcfg_r.double_click <= cfg_data;
        bgd_pkg::REG_REPEAT:       tcfg_r.repeat_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: sweep reads, write-back in the cycle after each read, result hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wb_vld_r    <= 1'b0;
      time_r      <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      act_r       <= bgd_pkg::ACT_TICK;
      cnt_r       <= '0;
      ev_r        <= bgd_pkg::EV_NONE;
    end else begin
      wb_vld_r  <= rd_en;
      wb_addr_r <= cnt_r;

      if (mem_we && (act_r == bgd_pkg::ACT_TICK)) begin
        for (int j = 0; j < NT; j++) begin
          if (32'(wb_addr_r) == j) begin
            mask_r[j] <= upd_entry.pressed_now;
          end
        end
      end
      if (wb_vld_r && (act_r == bgd_pkg::ACT_POLL)) begin
        ev_r <= upd_ev;
      end

      // a result taken with no new one behind it empties the output register
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            act_r    <= in_action;
            levels_r <= in_raw_levels;
            ev_r     <= bgd_pkg::EV_NONE;
            if (in_action == bgd_pkg::ACT_TICK) begin
              time_r  <= time_r + 1'b1;
              cnt_r   <= '0;
              state_r <= S_RUN;
            end else if (idx_ok) begin
              cnt_r   <= poll_addr;
              state_r <= S_RUN;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_RUN: begin
          if ((act_r == bgd_pkg::ACT_POLL) || (cnt_r == AW'(NT - 1))) begin
            state_r <= S_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_ev_r    <= ev_r;
            out_mask_r  <= mask_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_code   = out_ev_r;
  assign out_pressed_mask = out_mask_r;

  // write-back never lands on the record being read in the same cycle
  `BGD_ASSERT(a_no_rw_clash, (mem_we && rd_en) |-> (wb_addr_r != cnt_r), "read/write clash")
  // the memory is only written while a request is being worked on
  `BGD_ASSERT(a_we_busy, mem_we |-> (state_r == S_RUN || state_r == S_DRAIN), "stray write")
  // a tick advances the clock by exactly one
  `BGD_ASSERT(a_tick_time, (in_acc && in_action == bgd_pkg::ACT_TICK) |=> (time_r == $past(time_r) + 1'b1), "clock step")
  // a tick result never carries an event
  `BGD_ASSERT(a_tick_none, (out_load && act_r == bgd_pkg::ACT_TICK) |=> (out_event_code == bgd_pkg::EV_NONE), "tick event")

endmodule

### rtl/bgd_mem.sv
// Per-button state memory: one write port, one registered read port.
module bgd_mem #(
  parameter int DEPTH = bgd_pkg::BUTTON_COUNT_DEF,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  bgd_pkg::entry_t  wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output bgd_pkg::entry_t  rdata
);

  bgd_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  bgd_pkg::entry_t  rdata_r;

  // valid bits stand in for the all-zero reset of the records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/bgd_upd.sv
// Read-modify-write logic for one button record: tick update or poll.
module bgd_upd (
  input  logic                          is_poll,
  input  logic                          level,
  input  logic [bgd_pkg::STAMP_W-1:0]   now,
  input  bgd_pkg::timing_t              tcfg,
  input  bgd_pkg::entry_t               cur,
  output bgd_pkg::entry_t               nxt,
  output bgd_pkg::event_t               ev
);

  logic [bgd_pkg::STAMP_W-1:0] dc, dp, dl, dr, dp2, dr2, dl2, rp;
  logic [bgd_pkg::STAMP_W-1:0] deb_w, lp_w, dct_w, rt_w;
  logic chg, pressing, releasing, long_set;
  bgd_pkg::entry_t e;

  assign deb_w = {{(bgd_pkg::STAMP_W-8){1'b0}}, tcfg.debounce};
  assign lp_w  = {{(bgd_pkg::STAMP_W-16){1'b0}}, tcfg.long_press};
  assign dct_w = {{(bgd_pkg::STAMP_W-16){1'b0}}, tcfg.double_click};
  assign rt_w  = {{(bgd_pkg::STAMP_W-16){1'b0}}, tcfg.repeat_ms};

  // elapsed times against the stored stamps, all modulo 2^32
  assign dc = now - cur.change_stamp;
  assign dp = now - cur.press_stamp;
  assign dl = now - cur.release_stamp;
  assign dr = now - cur.repeat_stamp;
  assign rp = cur.release_stamp - cur.press_stamp;

  assign chg       = (level != cur.pressed_now) && (dc > deb_w);
  assign pressing  = chg && level;
  assign releasing = chg && !level;

  // a stamp just set to now gives an elapsed time of zero
  assign dp2 = pressing  ? '0 : dp;
  assign dl2 = releasing ? '0 : dl;

  always_comb begin
    e = cur;
    if (chg) begin
      e.pressed_before = cur.pressed_now;
      e.pressed_now    = level;
      e.change_stamp   = now;
      if (level) begin
        e.press_stamp   = now;
        e.long_flag     = 1'b0;
        e.long_reported = 1'b0;
        e.repeat_flag   = 1'b0;
      end else begin
        e.release_stamp = now;
        if (dp < lp_w) begin
          if ((cur.click_tally != '0) && (dl < dct_w)) begin
            if (cur.click_tally != '1) begin
              e.click_tally = cur.click_tally + 1'b1;
            end
          end else begin
            e.click_tally = 4'd1;
          end
        end
      end
    end
  end

  assign long_set = e.pressed_now && !e.long_flag && (dp2 >= lp_w);
  assign dr2      = long_set ? '0 : dr;

  always_comb begin
    nxt = e;
    ev  = bgd_pkg::EV_NONE;
    if (is_poll) begin
      nxt = cur;
      if (cur.click_tally >= 4'd2) begin
        nxt.click_tally = '0;
        ev = bgd_pkg::EV_DOUBLE;
      end else if (cur.long_flag && !cur.long_reported) begin
        nxt.long_reported = 1'b1;
        ev = bgd_pkg::EV_LONG;
      end else if (cur.repeat_flag) begin
        nxt.repeat_flag = 1'b0;
        ev = bgd_pkg::EV_REPEAT;
      end else if (cur.pressed_now && !cur.pressed_before) begin
        nxt.pressed_before = 1'b1;
        ev = bgd_pkg::EV_PRESSED;
      end else if (!cur.pressed_now && cur.pressed_before) begin
        nxt.pressed_before = 1'b0;
        ev = (rp < lp_w) ? bgd_pkg::EV_CLICK : bgd_pkg::EV_RELEASED;
      end
    end else begin
      if (long_set) begin
        nxt.long_flag    = 1'b1;
        nxt.repeat_stamp = now;
      end
      if (e.pressed_now && (e.long_flag || long_set) && !e.repeat_flag && (dr2 >= rt_w)) begin
        nxt.repeat_flag  = 1'b1;
        nxt.repeat_stamp = now;
      end
      if ((e.click_tally != '0) && (dl2 > dct_w)) begin
        nxt.click_tally = '0;
      end
    end
  end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the button gesture detector: directed table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bgd_pkg::*;

  localparam int NBTN         = BUTTON_COUNT_DEF;
  localparam int HOLD_CYCLES  = 250;  // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 16;   // extra wait at the end, longer than a tick
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 160;
  localparam int PLAN_LEN     = 31;

  // register indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_POLL,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    event_t                ev;
    logic [LEVEL_BITS-1:0] mask;
  } gesture_res_t;

  // arg: levels for a tick, button for a poll, write data for a register row
  typedef struct packed {
    row_kind_t             kind;
    logic [15:0]           arg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    bit                    typed;
    event_t                ev;
    logic [LEVEL_BITS-1:0] mask;
  } plan_row_t;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic                  in_action        = ACT_TICK;
  logic [LEVEL_BITS-1:0] in_raw_levels    = '0;
  logic [INDEX_W-1:0]    in_button_index  = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [2:0]            out_event_code;
  logic [LEVEL_BITS-1:0] out_pressed_mask;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  button_gesture_detector #(
    .BUTTON_COUNT(NBTN)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_raw_levels    (in_raw_levels),
    .in_button_index  (in_button_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_code   (out_event_code),
    .out_pressed_mask (out_pressed_mask),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Gesture predictor: own copy of the clock, per-button records and registers
  // ---------------------------------------------------------------------------
  logic [31:0]           ms_now;
  logic                  btn_down  [NBTN];
  logic                  btn_seen  [NBTN];  // debounced level before the last change, or as last reported by a poll
  logic [31:0]           down_at   [NBTN];
  logic [31:0]           up_at     [NBTN];
  logic [31:0]           moved_at  [NBTN];
  logic [31:0]           rpt_at    [NBTN];
  logic [TALLY_W-1:0]    clicks    [NBTN];
  logic                  held_long [NBTN];
  logic                  long_told [NBTN];
  logic                  rpt_due   [NBTN];

  logic [LEVEL_BITS-1:0] en_bits;
  logic [7:0]            settle_ms;
  logic [15:0]           hold_ms;
  logic [15:0]           dbl_ms;
  logic [15:0]           rpt_ms;

  gesture_res_t gesture_due[$];  // results still owed by the block, oldest first
  int           fault_count = 0;

  // sender / receiver pacing
  bit idle_on   = 1'b1;
  bit no_idle   = 1'b0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_cnt  = 0;
  int burst_cnt = 0;
  int free_cnt  = 0;

  gesture_res_t head;

  function automatic gesture_res_t predict_gesture(logic act, logic [LEVEL_BITS-1:0] lv,
                                                   logic [INDEX_W-1:0] bi);
    gesture_res_t r;
    logic [31:0]  prior;
    r.ev   = EV_NONE;
    r.mask = '0;
    if (act == ACT_TICK) begin
      ms_now = ms_now + 32'd1;
      for (int b = 0; b < NBTN; b++) begin
        if (!en_bits[b]) continue;
        // debounce: a change needs more than the settle time since the last one
        if (lv[b] != btn_down[b] && (ms_now - moved_at[b]) > settle_ms) begin
          btn_seen[b] = btn_down[b];
          btn_down[b] = lv[b];
          moved_at[b] = ms_now;
          if (lv[b]) begin
            down_at[b]   = ms_now;
            held_long[b] = 1'b0;
            long_told[b] = 1'b0;
            rpt_due[b]   = 1'b0;
          end else begin
            prior    = up_at[b];
            up_at[b] = ms_now;
            // short press is a click; tally runs on within the window between releases
            if ((ms_now - down_at[b]) < hold_ms) begin
              if (clicks[b] != 0 && (ms_now - prior) < dbl_ms) begin
                if (clicks[b] != 4'd15) clicks[b] = clicks[b] + 4'd1;
              end else begin
                clicks[b] = 4'd1;
              end
            end
          end
        end
        if (btn_down[b] && !held_long[b] && (ms_now - down_at[b]) >= hold_ms) begin
          held_long[b] = 1'b1;
          rpt_at[b]    = ms_now;
        end
        if (btn_down[b] && held_long[b] && !rpt_due[b] && (ms_now - rpt_at[b]) >= rpt_ms) begin
          rpt_due[b] = 1'b1;
          rpt_at[b]  = ms_now;
        end
        if (clicks[b] != 0 && (ms_now - up_at[b]) > dbl_ms) clicks[b] = '0;
      end
    end else if (bi < NBTN) begin
      // highest priority pending event wins and is cleared
      if (clicks[bi] >= 2) begin
        clicks[bi] = '0;
        r.ev       = EV_DOUBLE;
      end else if (held_long[bi] && !long_told[bi]) begin
        long_told[bi] = 1'b1;
        r.ev          = EV_LONG;
      end else if (rpt_due[bi]) begin
        rpt_due[bi] = 1'b0;
        r.ev        = EV_REPEAT;
      end else if (btn_down[bi] && !btn_seen[bi]) begin
        btn_seen[bi] = 1'b1;
        r.ev         = EV_PRESSED;
      end else if (!btn_down[bi] && btn_seen[bi]) begin
        btn_seen[bi] = 1'b0;
        r.ev         = ((up_at[bi] - down_at[bi]) < hold_ms) ? EV_CLICK : EV_RELEASED;
      end
    end
    for (int b = 0; b < NBTN; b++) r.mask[b] = btn_down[b];
    return r;
  endfunction

  // Offer one request and hold it until taken; the prediction is made at the accepting edge.
  // A typed row pushes its written-in result instead of the predicted one.
  task automatic offer(input logic act, input logic [LEVEL_BITS-1:0] lv,
                       input logic [INDEX_W-1:0] bi, input bit typed, input gesture_res_t want);
    gesture_res_t got;
    cfg_valid <= 1'b0;
    if (idle_on && !no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_raw_levels   <= lv;
    in_button_index <= bi;
    do @(posedge clk); while (in_stall);
    got = predict_gesture(act, lv, bi);
    gesture_due.push_back(typed ? want : got);
  endtask

  // Register write, only once every owed result has come back.
  // cfg_valid stays up for a following write; the next request lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] wd);
    in_valid <= 1'b0;
    while (gesture_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= wd;
    do @(posedge clk); while (!cfg_ready);
    case (ri)
      REG_ENABLE:       en_bits   = wd[LEVEL_BITS-1:0];
      REG_DEBOUNCE:     settle_ms = wd[7:0];
      REG_LONG_PRESS:   hold_ms   = wd;
      REG_DOUBLE_CLICK: dbl_ms    = wd;
      REG_REPEAT:       rpt_ms    = wd;
      default: ;
    endcase
  endtask

  // Directed table: reset state and bad indexes with typed results, then a short
  // walk through press, long press, repeat, release, click and double click.
  plan_row_t plan [PLAN_LEN] = '{
    // kind      arg       reg_idx       typed ev        mask
    '{ROW_POLL, 16'd0,    REG_ENABLE,   1'b1, EV_NONE, 6'd0},  // nothing pending after reset
    '{ROW_POLL, 16'd7,    REG_ENABLE,   1'b1, EV_NONE, 6'd0},  // index past the last button
    '{ROW_TICK, 16'd63,   REG_ENABLE,   1'b1, EV_NONE, 6'd0},  // debounce holds the first change
    '{ROW_POLL, 16'd6,    REG_ENABLE,   1'b1, EV_NONE, 6'd0},
    '{ROW_REG,  16'd0,    REG_DEBOUNCE, 1'b0, EV_NONE, 6'd0},
    '{ROW_REG,  16'd3,    REG_LONG_PRESS, 1'b0, EV_NONE, 6'd0},
    '{ROW_REG,  16'd6,    REG_DOUBLE_CLICK, 1'b0, EV_NONE, 6'd0},
    '{ROW_REG,  16'd0,    REG_REPEAT,   1'b0, EV_NONE, 6'd0},  // repeat latches with long press
    '{ROW_REG,  16'hFFFF, REG_SPARE_LO, 1'b0, EV_NONE, 6'd0},  // no such register
    '{ROW_REG,  16'h0000, REG_SPARE_HI, 1'b0, EV_NONE, 6'd0},
    '{ROW_TICK, 16'd63,   REG_ENABLE,   1'b0, EV_NONE, 6'd0},  // all buttons down
    '{ROW_POLL, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_TICK, 16'd63,   REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_TICK, 16'd63,   REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_TICK, 16'd63,   REG_ENABLE,   1'b0, EV_NONE, 6'd0},  // long press and repeat latch
    '{ROW_POLL, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_POLL, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_POLL, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_POLL, 16'd1,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_TICK, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},  // release after a long hold
    '{ROW_POLL, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_TICK, 16'd1,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},  // two quick clicks on button 0
    '{ROW_TICK, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_TICK, 16'd1,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_TICK, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_POLL, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_POLL, 16'd0,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},
    '{ROW_REG,  16'hFFC0, REG_ENABLE,   1'b0, EV_NONE, 6'd0},  // upper bits dropped: none enabled
    '{ROW_TICK, 16'd63,   REG_ENABLE,   1'b0, EV_NONE, 6'd0},  // disabled buttons stay frozen
    '{ROW_POLL, 16'd2,    REG_ENABLE,   1'b0, EV_NONE, 6'd0},  // still pollable
    '{ROW_REG,  16'h003F, REG_ENABLE,   1'b0, EV_NONE, 6'd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]            s_db;
    logic [15:0]           s_lp;
    logic [15:0]           s_dc;
    logic [15:0]           s_rp;
    logic [LEVEL_BITS-1:0] s_en;
    logic [LEVEL_BITS-1:0] lvl_vec;
    logic [LEVEL_BITS-1:0] noisy;
    int                    dwell [NBTN];
    int                    lp_c;
    int                    dc_c;
    int                    rp_c;
    int                    k;

    ms_now    = '0;
    en_bits   = ENABLE_RST;
    settle_ms = DEBOUNCE_RST;
    hold_ms   = LONG_PRESS_RST;
    dbl_ms    = DOUBLE_CLICK_RST;
    rpt_ms    = REPEAT_RST;
    for (int b = 0; b < NBTN; b++) begin
      btn_down[b]  = 1'b0;
      btn_seen[b]  = 1'b0;
      down_at[b]   = '0;
      up_at[b]     = '0;
      moved_at[b]  = '0;
      rpt_at[b]    = '0;
      clicks[b]    = '0;
      held_long[b] = 1'b0;
      long_told[b] = 1'b0;
      rpt_due[b]   = 1'b0;
      dwell[b]     = $urandom_range(0, 10);
    end
    lvl_vec = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      case (plan[i].kind)
        ROW_REG:  write_reg(plan[i].reg_idx, plan[i].arg);
        ROW_TICK: offer(ACT_TICK, plan[i].arg[LEVEL_BITS-1:0], 3'($urandom_range(0, 7)),
                        plan[i].typed, '{plan[i].ev, plan[i].mask});
        default:  offer(ACT_POLL, 6'($urandom_range(0, 63)), plan[i].arg[INDEX_W-1:0],
                        plan[i].typed, '{plan[i].ev, plan[i].mask});
      endcase
    end

    // Random phases. Timings are mostly small so long press, repeat and the
    // click window all come around within a few dozen ticks.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          s_db = 8'd2;  s_lp = 16'd12;    s_dc = 16'd10;    s_rp = 16'd3;    s_en = 6'd63;
        end
        1: begin  // smallest debounce, all other timing registers at one
          s_db = 8'd0;  s_lp = 16'd1;     s_dc = 16'd1;     s_rp = 16'd1;
          s_en = 6'($urandom_range(0, 63));
        end
        2: begin  // high end
          s_db = 8'd255; s_lp = 16'hFFFF; s_dc = 16'hFFFF; s_rp = 16'hFFFF; s_en = 6'd63;
        end
        default: begin
          s_db = 8'($urandom_range(0, 6));
          s_lp = 16'($urandom_range(2, 30));
          s_dc = 16'($urandom_range(2, 30));
          s_rp = 16'($urandom_range(0, 8));
          s_en = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63)) : 6'd63;
        end
      endcase
      if (ph == PHASES - 1) no_idle = 1'b1;  // closing stretch runs flat out

      write_reg(REG_ENABLE, {10'd0, s_en});
      write_reg(REG_DEBOUNCE, {8'd0, s_db});
      write_reg(REG_LONG_PRESS, s_lp);
      write_reg(REG_DOUBLE_CLICK, s_dc);
      write_reg(REG_REPEAT, s_rp);

      // receiver goes quiet for a long while, sender keeps pushing
      if (ph == 3 || ph == 5) hold_asks = hold_asks + 1;

      lp_c = s_lp; if (lp_c > 40) lp_c = 40;
      dc_c = s_dc; if (dc_c > 40) dc_c = 40;
      rp_c = s_rp; if (rp_c > 10) rp_c = 10;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
        if ($urandom_range(0, 2) == 0) begin
          // mostly real buttons, now and then an index past the end
          if ($urandom_range(0, 9) < 9) k = $urandom_range(0, NBTN - 1);
          else k = $urandom_range(NBTN, 7);
          offer(ACT_POLL, 6'($urandom_range(0, 63)), 3'(k), 1'b0, '0);
        end else begin
          // each contact dwells long enough to pass debounce: short presses for
          // clicks, long holds for long press and repeat, short gaps for doubles
          for (int b = 0; b < NBTN; b++) begin
            if (dwell[b] > 0) begin
              dwell[b] = dwell[b] - 1;
            end else begin
              lvl_vec[b] = !lvl_vec[b];
              if (lvl_vec[b]) begin
                if ($urandom_range(0, 1) == 0) dwell[b] = s_db + 1 + $urandom_range(0, lp_c);
                else dwell[b] = s_db + 1 + lp_c + $urandom_range(0, 4 * rp_c + 4);
              end else begin
                if ($urandom_range(0, 3) != 0) dwell[b] = s_db + 1 + $urandom_range(0, dc_c);
                else dwell[b] = s_db + 1 + $urandom_range(0, 3 * dc_c + 10);
              end
            end
          end
          // bounce and the odd garbage sample
          noisy = lvl_vec;
          if ($urandom_range(0, 15) == 0) begin
            k        = $urandom_range(0, NBTN - 1);
            noisy[k] = !noisy[k];
          end
          if ($urandom_range(0, 63) == 0) noisy = 6'($urandom_range(0, 63));
          offer(ACT_TICK, noisy, 3'($urandom_range(0, 7)), 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (gesture_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS button_gesture_detector");
    end else begin
      $display("FAIL button_gesture_detector");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, free stretches, and the long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen = hold_asks;
    end else begin
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else if (burst_cnt > 0) begin
        burst_cnt = burst_cnt - 1;
        out_stall <= 1'b1;
      end else if (free_cnt > 0) begin
        free_cnt = free_cnt - 1;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        free_cnt = $urandom_range(20, 60);
        out_stall <= 1'b0;
      end else begin
        burst_cnt = $urandom_range(1, 14) - 1;
        free_cnt  = $urandom_range(1, 8);
        out_stall <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (gesture_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got event %0d mask %b",
                 $time, out_event_code, out_pressed_mask);
        fault_count = fault_count + 1;
      end else begin
        head = gesture_due.pop_front();
        if (out_event_code !== head.ev) begin
          $display("%0t: event_code expected %0d got %0d", $time, head.ev, out_event_code);
          fault_count = fault_count + 1;
        end
        if (out_pressed_mask !== head.mask) begin
          $display("%0t: pressed_mask expected %b got %b", $time, head.mask, out_pressed_mask);
          fault_count = fault_count + 1;
        end
      end
    end
  end

  // hard stop, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("FAIL button_gesture_detector");
    $finish;
  end

endmodule
